// ===== rtl/core/ppu_pkg.sv =====
// ppu_pkg: shared constants, item/command types and fixed-point helpers
// for the particle pool update block. No dependencies.
`default_nettype none

package ppu_pkg;

    localparam int SLOTS      = 16;
    localparam int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int AXES       = 3;
    localparam int DATA_W     = 32;
    localparam int DAMP_W     = 16;
    localparam int AGE_W      = 16;
    localparam int SLOT_W     = 4;
    localparam int FRAC_SHIFT = 14;
    localparam int PROD_W     = DATA_W + DAMP_W + 1;
    localparam int RND_W      = PROD_W + 1;
    localparam int Q_W        = RND_W - FRAC_SHIFT;

    localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(SLOTS - 1);
    localparam logic [RND_W-1:0]  ROUND_BIAS = RND_W'(1) << (FRAC_SHIFT - 1);
    localparam logic [DATA_W-1:0] S_MAX      = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] S_MIN      = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic
    {
        KIND_ADD  = 1'b0,
        KIND_TICK = 1'b1
    } kind_t;

    typedef struct packed
    {
        logic [AXES-1:0][DATA_W-1:0] pos;
        logic [AXES-1:0][DATA_W-1:0] vel;
        logic [AXES-1:0][DAMP_W-1:0] damp;
        logic [AGE_W-1:0]            lifespan;
    } in_item_t;

    typedef struct packed
    {
        logic             load;
        logic             add_place;
        logic             add_full;
        logic             mul;
        logic             wb;
        logic [IDX_W-1:0] idx;
    } cmd_t;

    typedef struct packed
    {
        logic used_cur;
        logic out_free;
    } status_t;

    // saturating signed add
    function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
                                                  input logic [DATA_W-1:0] b);
        logic [DATA_W:0] s;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1])
        begin
            return s[DATA_W] ? S_MIN : S_MAX;
        end
        return s[DATA_W-1:0];
    endfunction

    // round Q18.30 product to Q16.16 (floor of (p + 2^13) / 2^14), saturate
    function automatic logic [DATA_W-1:0] round_damp(input logic [PROD_W-1:0] p);
        logic [RND_W-1:0] r;
        logic [Q_W-1:0]   q;
        r = {p[PROD_W-1], p} + ROUND_BIAS;
        q = r[RND_W-1:FRAC_SHIFT];
        if ((q[Q_W-1:DATA_W-1] == '0) || (q[Q_W-1:DATA_W-1] == '1))
        begin
            return q[DATA_W-1:0];
        end
        return q[Q_W-1] ? S_MIN : S_MAX;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ppu_in_if.sv =====
// ppu_in_if: valid/ready channel carrying one input item.
// Depends on ppu_pkg for field widths.
`default_nettype none

interface ppu_in_if import ppu_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic                     kind;
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] pos_z;
    logic signed [DATA_W-1:0] vel_x;
    logic signed [DATA_W-1:0] vel_y;
    logic signed [DATA_W-1:0] vel_z;
    logic [DAMP_W-1:0]        damp_x;
    logic [DAMP_W-1:0]        damp_y;
    logic [DAMP_W-1:0]        damp_z;
    logic [AGE_W-1:0]         lifespan;

    modport source (output valid, kind, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                    damp_x, damp_y, damp_z, lifespan, input ready);
    modport sink   (input valid, kind, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                    damp_x, damp_y, damp_z, lifespan, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ppu_out_if.sv =====
// ppu_out_if: valid/ready channel carrying one result item.
// Depends on ppu_pkg for field widths.
`default_nettype none

interface ppu_out_if import ppu_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [SLOT_W-1:0]        slot;
    logic                     alive;
    logic signed [DATA_W-1:0] out_x;
    logic signed [DATA_W-1:0] out_y;
    logic signed [DATA_W-1:0] out_z;
    logic                     accepted;
    logic                     last;

    modport source (output valid, slot, alive, out_x, out_y, out_z, accepted, last,
                    input ready);
    modport sink   (input valid, slot, alive, out_x, out_y, out_z, accepted, last,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ppu_ctrl.sv =====
// ppu_ctrl: sequencer for add scans and tick walks over the slot pool.
// Depends on ppu_pkg; drives commands into ppu_datapath.
`default_nettype none

module ppu_ctrl import ppu_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    input  wire logic    in_kind,
    output logic         in_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_SCAN,
        S_MUL,
        S_WB
    } state_t;

    state_t           state_reg;
    logic [IDX_W-1:0] idx_reg;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd     = '0;
        cmd.idx = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = in_valid;
            end
            S_SCAN:
            begin
                if (status.out_free)
                begin
                    cmd.add_place = !status.used_cur;
                    cmd.add_full  = status.used_cur && (idx_reg == LAST_IDX);
                end
            end
            S_MUL:
            begin
                cmd.mul = 1'b1;
            end
            S_WB:
            begin
                cmd.wb = status.out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        idx_reg   <= '0;
                        state_reg <= (in_kind == KIND_TICK) ? S_MUL : S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (cmd.add_place || cmd.add_full)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (status.used_cur && (idx_reg != LAST_IDX))
                    begin
                        idx_reg <= IDX_W'(idx_reg + 1'b1);
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_WB;
                end
                S_WB:
                begin
                    if (cmd.wb)
                    begin
                        if (idx_reg == LAST_IDX)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= IDX_W'(idx_reg + 1'b1);
                            state_reg <= S_MUL;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/ppu_datapath.sv =====
// ppu_datapath: slot storage, damping multipliers, saturating update and
// the result register. Depends on ppu_pkg and ppu_out_if.
`default_nettype none

module ppu_datapath import ppu_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     cfg_we,
    input  wire logic     cfg_wdata,
    input  wire in_item_t in_item,
    input  wire cmd_t     cmd,
    output status_t       status,
    ppu_out_if.source     results
);

    logic                    move_enable_reg;
    logic [SLOTS-1:0]        used_reg;
    logic [AGE_W-1:0]        age_reg  [SLOTS];
    logic [AGE_W-1:0]        life_reg [SLOTS];
    logic [DATA_W-1:0]       pos_reg  [SLOTS][AXES];
    logic [DATA_W-1:0]       vel_reg  [SLOTS][AXES];
    logic [DAMP_W-1:0]       damp_reg [SLOTS][AXES];

    in_item_t                item_reg;

    // multiply stage
    logic [PROD_W-1:0]       prod_reg [AXES];
    logic [DATA_W-1:0]       psum_reg [AXES];
    logic                    expire_reg;

    // result register
    logic                    out_valid_reg;
    logic [SLOT_W-1:0]       out_slot_reg;
    logic                    out_alive_reg;
    logic [AXES-1:0][DATA_W-1:0] out_pos_reg;
    logic                    out_acc_reg;
    logic                    out_last_reg;

    logic                    used_cur;
    logic                    survive;
    logic                    emit;

    assign used_cur        = used_reg[cmd.idx];
    assign survive         = used_cur && !expire_reg;
    assign emit            = cmd.add_place || cmd.add_full || cmd.wb;
    assign status.used_cur = used_cur;
    assign status.out_free = !out_valid_reg || results.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            move_enable_reg <= 1'b1;
            used_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                move_enable_reg <= cfg_wdata;
            end
            if (cmd.add_place)
            begin
                used_reg[cmd.idx] <= 1'b1;
            end
            else if (cmd.wb && used_cur && expire_reg)
            begin
                used_reg[cmd.idx] <= 1'b0;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_item;
        end

        if (cmd.add_place)
        begin
            age_reg[cmd.idx]  <= '0;
            life_reg[cmd.idx] <= item_reg.lifespan;
            for (int a = 0; a < AXES; a++)
            begin
                pos_reg[cmd.idx][a]  <= item_reg.pos[a];
                vel_reg[cmd.idx][a]  <= item_reg.vel[a];
                damp_reg[cmd.idx][a] <= item_reg.damp[a];
            end
        end

        if (cmd.mul)
        begin
            expire_reg <= (age_reg[cmd.idx] >= life_reg[cmd.idx]);
            for (int a = 0; a < AXES; a++)
            begin
                prod_reg[a] <= PROD_W'($signed(vel_reg[cmd.idx][a])
                                       * $signed({1'b0, damp_reg[cmd.idx][a]}));
                psum_reg[a] <= sat_add(pos_reg[cmd.idx][a], vel_reg[cmd.idx][a]);
            end
        end

        if (cmd.wb && survive)
        begin
            age_reg[cmd.idx] <= AGE_W'(age_reg[cmd.idx] + 1'b1);
            if (move_enable_reg)
            begin
                for (int a = 0; a < AXES; a++)
                begin
                    pos_reg[cmd.idx][a] <= psum_reg[a];
                    vel_reg[cmd.idx][a] <= round_damp(prod_reg[a]);
                end
            end
        end

        if (cmd.add_place)
        begin
            out_slot_reg  <= SLOT_W'(cmd.idx);
            out_alive_reg <= 1'b1;
            out_pos_reg   <= item_reg.pos;
            out_acc_reg   <= 1'b1;
            out_last_reg  <= 1'b1;
        end
        else if (cmd.add_full)
        begin
            out_slot_reg  <= '0;
            out_alive_reg <= 1'b0;
            out_pos_reg   <= '0;
            out_acc_reg   <= 1'b0;
            out_last_reg  <= 1'b1;
        end
        else if (cmd.wb)
        begin
            out_slot_reg  <= SLOT_W'(cmd.idx);
            out_alive_reg <= survive;
            out_acc_reg   <= 1'b0;
            out_last_reg  <= (cmd.idx == LAST_IDX);
            for (int a = 0; a < AXES; a++)
            begin
                if (!survive)
                begin
                    out_pos_reg[a] <= '0;
                end
                else if (move_enable_reg)
                begin
                    out_pos_reg[a] <= psum_reg[a];
                end
                else
                begin
                    out_pos_reg[a] <= pos_reg[cmd.idx][a];
                end
            end
        end
    end

    assign results.valid    = out_valid_reg;
    assign results.slot     = out_slot_reg;
    assign results.alive    = out_alive_reg;
    assign results.out_x    = out_pos_reg[0];
    assign results.out_y    = out_pos_reg[1];
    assign results.out_z    = out_pos_reg[2];
    assign results.accepted = out_acc_reg;
    assign results.last     = out_last_reg;

endmodule

`default_nettype wire

// ===== rtl/core/particle_pool_update_top.sv =====
// particle_pool_update_top: pool of SLOTS particles, one item at a time.
// Add: the scan checks one slot per cycle; the result for the first free slot, or a drop
// result if the pool is full, is registered once the result register is free. Tick: one
// result per slot via a read/multiply step and a write-back step that waits for a free
// result register. The next item can be taken the cycle after the last result is registered.
// Reset (async, active low) clears all slot-used bits and sets move_enable to 1; no clear pass.
`default_nettype none

module particle_pool_update_top import ppu_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_we,
    input  wire logic cfg_wdata,
    ppu_in_if.sink    items,
    ppu_out_if.source results
);

    cmd_t     cmd;
    status_t  status;
    in_item_t in_item;
    logic     in_ready;

    assign items.ready = in_ready;

    assign in_item.pos[0]   = items.pos_x;
    assign in_item.pos[1]   = items.pos_y;
    assign in_item.pos[2]   = items.pos_z;
    assign in_item.vel[0]   = items.vel_x;
    assign in_item.vel[1]   = items.vel_y;
    assign in_item.vel[2]   = items.vel_z;
    assign in_item.damp[0]  = items.damp_x;
    assign in_item.damp[1]  = items.damp_y;
    assign in_item.damp[2]  = items.damp_z;
    assign in_item.lifespan = items.lifespan;

    ppu_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (items.valid),
        .in_kind  (items.kind),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    ppu_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_item   (in_item),
        .cmd       (cmd),
        .status    (status),
        .results   (results)
    );

    a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        items.valid && items.ready |=> !items.ready)
        else $error("input accepted twice in a row");

    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.add_place, cmd.add_full, cmd.mul, cmd.wb}))
        else $error("conflicting datapath commands");

    a_dead_zero: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && !results.alive |->
            results.out_x == 0 && results.out_y == 0 && results.out_z == 0)
        else $error("dead slot reports nonzero position");

    a_accept_final: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.accepted |-> results.alive && results.last)
        else $error("placed add result malformed");

    a_wb_emits: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wb |=> results.valid)
        else $error("tick write-back produced no result");

endmodule

`default_nettype wire

// ===== tb/sv/particle_pool_update_top_tb.sv =====
// particle_pool_update_top_tb: self-checking bench for the particle pool block.
// Keeps its own copy of the pool, predicts every result item and checks it.
// Depends on ppu_pkg, ppu_in_if, ppu_out_if and particle_pool_update_top.
`default_nettype none

module particle_pool_update_top_tb import ppu_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed
    {
        kind_t    kind;
        in_item_t body;
    } stim_t;

    typedef struct packed
    {
        logic [SLOT_W-1:0]           slot;
        logic                        alive;
        logic [AXES-1:0][DATA_W-1:0] pos;
        logic                        accepted;
        logic                        last;
    } report_t;

    typedef struct
    {
        logic             used;
        logic [AGE_W-1:0] age;
        in_item_t         p;
    } particle_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    ppu_in_if  items();
    ppu_out_if results();

    particle_pool_update_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .items     (items),
        .results   (results)
    );

    always #10 clk = ~clk;

    particle_t pool [SLOTS];
    bit        motion_on;
    report_t   pending_reports [$];
    int        report_errors = 0;
    int        hold_cycles = 0;
    int        src_calm = 0;
    int        snk_calm = 0;

    function automatic logic [DATA_W-1:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
        begin
            return S_MAX;
        end
        if (v < -64'sd2147483648)
        begin
            return S_MIN;
        end
        return v[DATA_W-1:0];
    endfunction

    // mostly no gap, some short ones, a few long, with calm stretches between
    function automatic int idle_len(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if ($urandom_range(0, 2) != 0)
        begin
            return 0;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            return $urandom_range(12, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    function automatic void place_particle(input in_item_t b);
        report_t r;
        r = '0;
        r.last = 1'b1;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!pool[i].used)
            begin
                pool[i].used = 1'b1;
                pool[i].age  = '0;
                pool[i].p    = b;
                r.slot       = SLOT_W'(i);
                r.alive      = 1'b1;
                r.pos        = b.pos;
                r.accepted   = 1'b1;
                pending_reports.push_back(r);
                return;
            end
        end
        // pool full: item dropped, report carries zeros
        pending_reports.push_back(r);
    endfunction

    function automatic void advance_pool();
        report_t r;
        longint  prod;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (pool[i].used)
            begin
                if (pool[i].age >= pool[i].p.lifespan)
                begin
                    pool[i].used = 1'b0;
                end
                else
                begin
                    pool[i].age = pool[i].age + 1'b1;
                    if (motion_on)
                    begin
                        for (int a = 0; a < AXES; a++)
                        begin
                            pool[i].p.pos[a] = clamp32(longint'($signed(pool[i].p.pos[a]))
                                                     + longint'($signed(pool[i].p.vel[a])));
                            // Q16.16 x Q2.14, round half up, floor shift
                            prod = longint'($signed(pool[i].p.vel[a]))
                                 * longint'(pool[i].p.damp[a]) + 64'sd8192;
                            pool[i].p.vel[a] = clamp32(prod >>> FRAC_SHIFT);
                        end
                    end
                end
            end
            r      = '0;
            r.slot = SLOT_W'(i);
            r.last = (i == SLOTS - 1);
            if (pool[i].used)
            begin
                r.alive = 1'b1;
                r.pos   = pool[i].p.pos;
            end
            pending_reports.push_back(r);
        end
    endfunction

    function automatic logic [DATA_W-1:0] rand_word();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($urandom_range(0, 32'h001F_FFFF)) - 32'h0010_0000;
            2: return $urandom_range(0, 1) ? S_MAX - 32'($urandom_range(0, 255))
                                           : S_MIN + 32'($urandom_range(0, 255));
            default: return 32'($urandom_range(0, 3)) - 32'd1;
        endcase
    endfunction

    function automatic stim_t random_item();
        stim_t s;
        int    pick;
        if ($urandom_range(0, 99) < 55)
        begin
            s.kind = KIND_ADD;
        end
        else
        begin
            s.kind = KIND_TICK;
        end
        for (int a = 0; a < AXES; a++)
        begin
            s.body.pos[a] = rand_word();
            s.body.vel[a] = rand_word();
            case ($urandom_range(0, 2))
                0: s.body.damp[a] = DAMP_W'($urandom_range(0, 65535));
                1: s.body.damp[a] = DAMP_W'($urandom_range(16'h3800, 16'h4200));
                default: s.body.damp[a] = $urandom_range(0, 1) ? '1 : '0;
            endcase
        end
        pick = $urandom_range(0, 99);
        if (pick < 75)
        begin
            s.body.lifespan = AGE_W'($urandom_range(0, 8));
        end
        else if (pick < 98)
        begin
            s.body.lifespan = AGE_W'($urandom_range(0, 40));
        end
        else
        begin
            s.body.lifespan = AGE_W'($urandom_range(0, 65535));
        end
        return s;
    endfunction

    task automatic send_item(input stim_t s);
        int gap;
        gap = idle_len(src_calm);
        repeat (gap)
        begin
            @(negedge clk);
            items.valid <= 1'b0;
        end
        @(negedge clk);
        items.kind     <= s.kind;
        items.pos_x    <= s.body.pos[0];
        items.pos_y    <= s.body.pos[1];
        items.pos_z    <= s.body.pos[2];
        items.vel_x    <= s.body.vel[0];
        items.vel_y    <= s.body.vel[1];
        items.vel_z    <= s.body.vel[2];
        items.damp_x   <= s.body.damp[0];
        items.damp_y   <= s.body.damp[1];
        items.damp_z   <= s.body.damp[2];
        items.lifespan <= s.body.lifespan;
        items.valid    <= 1'b1;
        do
            @(posedge clk);
        while (items.ready !== 1'b1);
        if (s.kind == KIND_ADD)
        begin
            place_particle(s.body);
        end
        else
        begin
            advance_pool();
        end
    endtask

    task automatic send_add(input logic [DATA_W-1:0] px, py, pz, vx, vy, vz,
                            input logic [DAMP_W-1:0] dx, dy, dz,
                            input logic [AGE_W-1:0] life);
        stim_t s;
        s.kind          = KIND_ADD;
        s.body.pos      = {pz, py, px};
        s.body.vel      = {vz, vy, vx};
        s.body.damp     = {dz, dy, dx};
        s.body.lifespan = life;
        send_item(s);
    endtask

    task automatic send_tick();
        stim_t s;
        s      = random_item();
        s.kind = KIND_TICK;
        send_item(s);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        items.valid <= 1'b0;
        while (pending_reports.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic set_motion(input bit en);
        @(negedge clk);
        cfg_wdata <= en;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
        motion_on = en;
    endtask

    task automatic test_empty_tick();
        send_tick();
    endtask

    // zero lifespan lands in slot 0, the long-lived one goes last
    task automatic test_add_extremes();
        send_add($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 DAMP_W'($urandom), DAMP_W'($urandom), DAMP_W'($urandom), 16'd0);
        send_add(32'h0001_0000, 32'hFFFF_0000, 32'd0, 32'hFFFF_0000, 32'h0000_8000, 32'd7,
                 16'h0000, 16'h0000, 16'h0000, 16'd1);
        send_add(32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFD, 32'h0001_8000,
                 16'h2000, 16'h2000, 16'h4000, 16'd2);
        send_add(S_MIN, S_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, S_MIN,
                 16'h0000, 16'h2000, 16'h6000, 16'd3);
        send_add(S_MAX, S_MIN, 32'd0, S_MAX, S_MIN, 32'd1,
                 16'hFFFF, 16'hFFFF, 16'h4000, 16'hFFFF);
    endtask

    task automatic test_saturating_ticks();
        repeat (3)
        begin
            send_tick();
        end
    endtask

    // fill every free slot with motion off, then one add that must be dropped and a tick
    task automatic test_full_pool_frozen();
        stim_t s;
        int    live;
        wait_drained();
        set_motion(1'b0);
        live = 0;
        foreach (pool[i])
        begin
            live += pool[i].used;
        end
        repeat (SLOTS - live + 1)
        begin
            s               = random_item();
            s.kind          = KIND_ADD;
            s.body.lifespan = AGE_W'($urandom_range(0, 6));
            send_item(s);
        end
        send_tick();
        wait_drained();
        set_motion(1'b1);
    endtask

    // receiver holds off while ticks pile up and the input stalls
    task automatic test_output_backpressure();
        wait_drained();
        hold_cycles = 400;
        send_tick();
        repeat (2)
        begin
            send_add(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                     rand_word(), 16'h3C00, 16'h4000, 16'h4400, 16'd5);
        end
        repeat (3)
        begin
            send_tick();
        end
        wait_drained();
    endtask

    task automatic test_random_traffic();
        bit en;
        for (int ph = 0; ph < 6; ph++)
        begin
            wait_drained();
            if (ph == 1)
            begin
                en = 1'b0;
            end
            else if (ph == 3)
            begin
                en = 1'b1;
            end
            else
            begin
                en = $urandom_range(0, 1);
            end
            set_motion(en);
            repeat (70)
            begin
                send_item(random_item());
            end
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        report_t got;
        report_t want;
        if (rst_n === 1'b1 && results.valid === 1'b1 && results.ready === 1'b1)
        begin
            got.slot     = results.slot;
            got.alive    = results.alive;
            got.pos      = {results.out_z, results.out_y, results.out_x};
            got.accepted = results.accepted;
            got.last     = results.last;
            if (pending_reports.size() == 0)
            begin
                report_errors++;
                if (report_errors <= 10)
                begin
                    $display("unexpected result item: slot %0d alive %0b", got.slot, got.alive);
                end
            end
            else
            begin
                want = pending_reports.pop_front();
                if (got.slot !== want.slot || got.alive !== want.alive
                    || got.pos[0] !== want.pos[0] || got.pos[1] !== want.pos[1]
                    || got.pos[2] !== want.pos[2] || got.accepted !== want.accepted
                    || got.last !== want.last)
                begin
                    report_errors++;
                    if (report_errors <= 10)
                    begin
                        $display("mismatch: got slot %0d alive %0b x %h y %h z %h acc %0b last %0b",
                                 got.slot, got.alive, got.pos[0], got.pos[1], got.pos[2],
                                 got.accepted, got.last);
                        $display("     expected slot %0d alive %0b x %h y %h z %h acc %0b last %0b",
                                 want.slot, want.alive, want.pos[0], want.pos[1], want.pos[2],
                                 want.accepted, want.last);
                    end
                end
            end
        end
    end

    // result ready: random stalls, plus a long hold when requested
    initial
    begin
        int stall;
        stall = 0;
        results.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                results.ready <= 1'b0;
                hold_cycles--;
            end
            else if (stall > 0)
            begin
                results.ready <= 1'b0;
                stall--;
            end
            else
            begin
                stall = idle_len(snk_calm);
                results.ready <= (stall == 0);
                if (stall > 0)
                begin
                    stall--;
                end
            end
        end
    end

    initial
    begin
        #80_000_000;
        $display("particle_pool_update_top_tb NOT OK");
        $finish;
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = 1'b0;
        items.valid    = 1'b0;
        items.kind     = KIND_ADD;
        items.pos_x    = '0;
        items.pos_y    = '0;
        items.pos_z    = '0;
        items.vel_x    = '0;
        items.vel_y    = '0;
        items.vel_z    = '0;
        items.damp_x   = '0;
        items.damp_y   = '0;
        items.damp_z   = '0;
        items.lifespan = '0;
        motion_on      = 1'b1;
        foreach (pool[i])
        begin
            pool[i].used = 1'b0;
        end
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_tick();
        test_add_extremes();
        test_saturating_ticks();
        test_full_pool_frozen();
        test_output_backpressure();
        test_random_traffic();

        wait_drained();
        repeat (40) @(posedge clk);
        if (report_errors == 0 && pending_reports.size() == 0)
        begin
            $display("particle_pool_update_top_tb OK");
        end
        else
        begin
            $display("particle_pool_update_top_tb NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/core/ppu_pkg.sv
rtl/core/ppu_in_if.sv
rtl/core/ppu_out_if.sv
rtl/core/ppu_ctrl.sv
rtl/core/ppu_datapath.sv
rtl/core/particle_pool_update_top.sv
tb/sv/particle_pool_update_top_tb.sv
